### rtl/core/mlbs_pkg.sv
`default_nettype none
package mlbs_pkg;

  localparam int unsigned PIXEL_W         = 16;
  localparam int unsigned SUM_W           = 28;
  localparam int unsigned ROW_W           = 16;
  localparam int unsigned COL_W           = 12;
  localparam int unsigned LEN_W           = 13;
  localparam int unsigned LINES_W         = 16;
  localparam int unsigned LOOK_W          = 7;
  localparam int unsigned BASE_W          = 14;
  localparam int unsigned MAX_LINE_LENGTH = 4096;
  localparam int unsigned MAX_LOOKS       = 64;
  localparam int unsigned PART_DEPTH      = MAX_LINE_LENGTH;
  localparam int unsigned IN_TDATA_W      = 16;
  localparam int unsigned OUT_TDATA_W     = 56;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_COLUMNS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOOKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_LOOKS = 3'd4;

  localparam logic [LEN_W-1:0]   LEN_RESET   = 13'd4096;
  localparam logic [LEN_W-1:0]   VALID_RESET = 13'd4096;
  localparam logic [LINES_W-1:0] LINES_RESET = 16'hFFFF;
  localparam logic [LOOK_W-1:0]  LOOKS_RESET = 7'd1;

  // one tile closing on the current line
  typedef struct packed {
    logic [COL_W-1:0] tc;
    logic [SUM_W-1:0] acc;
    logic             first;
    logic             emit;
    logic [ROW_W-1:0] row;
    logic             last;
  } tile_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tile_res_t;

endpackage
`default_nettype wire

### rtl/core/multilook_block_sum_core.sv
// Multilook box-sum downsampler. Pixels stream in raster order on the slave
// side, one per clock when both sides keep up; each completed tile of
// azimuth_looks lines by range_looks columns leaves as one request on the
// master side. A pixel updates the line counters and, when it closes a
// tile, issues the partial-sum memory read; the sum is then added and
// written back, and then sits in the output register. The per-tile-column
// partial sums live in a 4096-entry memory with one read and one write per
// cycle; back-to-back tiles on the same column are forwarded. No clearing
// pass is needed: the first line of each group overwrites its entries. A
// register write restarts the frame and must be made while the block is idle.
`default_nettype none
module multilook_block_sum_core (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [mlbs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // pixel
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [mlbs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // tile_sum, out_row, out_col
  output logic                                 m_axis_tlast,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [mlbs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [mlbs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned SUM_W   = mlbs_pkg::SUM_W;
  localparam int unsigned LEN_W   = mlbs_pkg::LEN_W;
  localparam int unsigned LINES_W = mlbs_pkg::LINES_W;
  localparam int unsigned LOOK_W  = mlbs_pkg::LOOK_W;
  localparam int unsigned BASE_W  = mlbs_pkg::BASE_W;
  localparam int unsigned COL_W   = mlbs_pkg::COL_W;
  localparam int unsigned ROW_W   = mlbs_pkg::ROW_W;

  logic [LEN_W-1:0]   line_length_q, valid_columns_q;
  logic [LINES_W-1:0] line_count_q;
  logic [LOOK_W-1:0]  range_looks_q, azimuth_looks_q;
  logic               cfg_hit;

  logic [LEN_W-1:0]   len, valid;
  logic [LOOK_W-1:0]  rl, az;

  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [LEN_W-1:0]   col_q, col_d;
  logic [LOOK_W-1:0]  cit_q, cit_d;
  logic [BASE_W-1:0]  cbase_q, cbase_d;
  logic [COL_W-1:0]   tc_q, tc_d;
  logic [LINES_W-1:0] line_q, line_d;
  logic [LOOK_W-1:0]  lig_q, lig_d;
  logic [LINES_W-1:0] gbase_q, gbase_d;
  logic [ROW_W-1:0]   tr_q, tr_d;

  logic               accept, active, tile_end, line_end, grp_end, col_ok, row_ok;
  logic               last_col, last_row;
  logic [SUM_W-1:0]   acc_sum;
  logic [BASE_W:0]    cb_plus1, cb_plus2;
  logic [LINES_W:0]   gb_plus1, gb_plus2;

  mlbs_pkg::tile_req_t req;
  mlbs_pkg::tile_res_t res;
  logic                issue, s1_valid, s1_emit, s1_adv, out_free;
  logic                out_valid_q;
  mlbs_pkg::tile_res_t out_q;

  // register file
  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (cfg_index_i)
      mlbs_pkg::REG_LINE_LENGTH,
      mlbs_pkg::REG_VALID_COLUMNS,
      mlbs_pkg::REG_LINE_COUNT,
      mlbs_pkg::REG_RANGE_LOOKS,
      mlbs_pkg::REG_AZIMUTH_LOOKS: cfg_hit = cfg_valid_i;
      default:                     cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q   <= mlbs_pkg::LEN_RESET;
      valid_columns_q <= mlbs_pkg::VALID_RESET;
      line_count_q    <= mlbs_pkg::LINES_RESET;
      range_looks_q   <= mlbs_pkg::LOOKS_RESET;
      azimuth_looks_q <= mlbs_pkg::LOOKS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mlbs_pkg::REG_LINE_LENGTH:   line_length_q   <= cfg_data_i[LEN_W-1:0];
        mlbs_pkg::REG_VALID_COLUMNS: valid_columns_q <= cfg_data_i[LEN_W-1:0];
        mlbs_pkg::REG_LINE_COUNT:    line_count_q    <= cfg_data_i[LINES_W-1:0];
        mlbs_pkg::REG_RANGE_LOOKS:   range_looks_q   <= cfg_data_i[LOOK_W-1:0];
        mlbs_pkg::REG_AZIMUTH_LOOKS: azimuth_looks_q <= cfg_data_i[LOOK_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  always_comb begin
    if (line_length_q == '0) begin
      len = LEN_W'(1);
    end else if (line_length_q > LEN_W'(mlbs_pkg::MAX_LINE_LENGTH)) begin
      len = LEN_W'(mlbs_pkg::MAX_LINE_LENGTH);
    end else begin
      len = line_length_q;
    end
    if (range_looks_q == '0) begin
      rl = LOOK_W'(1);
    end else if (range_looks_q > LOOK_W'(mlbs_pkg::MAX_LOOKS)) begin
      rl = LOOK_W'(mlbs_pkg::MAX_LOOKS);
    end else begin
      rl = range_looks_q;
    end
    if (azimuth_looks_q == '0) begin
      az = LOOK_W'(1);
    end else if (azimuth_looks_q > LOOK_W'(mlbs_pkg::MAX_LOOKS)) begin
      az = LOOK_W'(mlbs_pkg::MAX_LOOKS);
    end else begin
      az = azimuth_looks_q;
    end
    valid = (valid_columns_q > len) ? len : valid_columns_q;
  end

  // tile and group bounds from running bases, no division
  assign cb_plus1 = {1'b0, cbase_q} + (BASE_W+1)'(rl);
  assign cb_plus2 = cb_plus1 + (BASE_W+1)'(rl);
  assign gb_plus1 = {1'b0, gbase_q} + (LINES_W+1)'(az);
  assign gb_plus2 = gb_plus1 + (LINES_W+1)'(az);

  assign col_ok   = cb_plus1 <= (BASE_W+1)'(valid);
  assign row_ok   = (line_q != {LINES_W{1'b1}}) && (gb_plus1 <= (LINES_W+1)'(line_count_q));
  assign last_col = cb_plus2 > (BASE_W+1)'(valid);
  assign last_row = gb_plus2 > (LINES_W+1)'(line_count_q);

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign active   = col_ok && row_ok;
  assign tile_end = ({1'b0, cit_q} + (LOOK_W+1)'(1)) >= (LOOK_W+1)'(rl);
  assign grp_end  = ({1'b0, lig_q} + (LOOK_W+1)'(1)) >= (LOOK_W+1)'(az);
  assign line_end = ({1'b0, col_q} + (LEN_W+1)'(1)) >= (LEN_W+1)'(len);
  assign acc_sum  = acc_q + SUM_W'(s_axis_tdata[mlbs_pkg::PIXEL_W-1:0]);

  always_comb begin
    acc_d   = acc_q;
    col_d   = col_q;
    cit_d   = cit_q;
    cbase_d = cbase_q;
    tc_d    = tc_q;
    line_d  = line_q;
    lig_d   = lig_q;
    gbase_d = gbase_q;
    tr_d    = tr_q;
    if (cfg_hit) begin
      acc_d   = '0;
      col_d   = '0;
      cit_d   = '0;
      cbase_d = '0;
      tc_d    = '0;
      line_d  = '0;
      lig_d   = '0;
      gbase_d = '0;
      tr_d    = '0;
    end else if (accept) begin
      if (active) begin
        acc_d = tile_end ? '0 : acc_sum;
      end
      if (line_end) begin
        col_d   = '0;
        cit_d   = '0;
        cbase_d = '0;
        tc_d    = '0;
        acc_d   = '0;
        lig_d   = grp_end ? '0 : lig_q + LOOK_W'(1);
        if (line_q != {LINES_W{1'b1}}) begin
          line_d = line_q + LINES_W'(1);
          if (grp_end) begin
            gbase_d = line_q + LINES_W'(1);
            tr_d    = tr_q + ROW_W'(1);
          end
        end
      end else begin
        col_d = col_q + LEN_W'(1);
        if (tile_end) begin
          cit_d   = '0;
          cbase_d = cb_plus1[BASE_W-1:0];
          tc_d    = tc_q + COL_W'(1);
        end else begin
          cit_d = cit_q + LOOK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      col_q   <= '0;
      cit_q   <= '0;
      cbase_q <= '0;
      tc_q    <= '0;
      line_q  <= '0;
      lig_q   <= '0;
      gbase_q <= '0;
      tr_q    <= '0;
    end else begin
      acc_q   <= acc_d;
      col_q   <= col_d;
      cit_q   <= cit_d;
      cbase_q <= cbase_d;
      tc_q    <= tc_d;
      line_q  <= line_d;
      lig_q   <= lig_d;
      gbase_q <= gbase_d;
      tr_q    <= tr_d;
    end
  end

  // partial-sum read-modify-write
  assign issue      = accept && active && tile_end;
  assign req.tc     = tc_q;
  assign req.acc    = acc_sum;
  assign req.first  = (lig_q == '0);
  assign req.emit   = grp_end;
  assign req.row    = tr_q;
  assign req.last   = last_row && last_col;

  mlbs_partials u_partials (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .req_i   (req),
    .adv_i   (s1_adv),
    .valid_o (s1_valid),
    .emit_o  (s1_emit),
    .res_o   (res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = !s1_emit || out_free;
  assign s_axis_tready = !s1_valid || s1_adv;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit && out_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.col, out_q.row, out_q.sum};
  assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire

### rtl/core/mlbs_partials.sv
`default_nettype none
module mlbs_partials (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   issue_i,
  input  mlbs_pkg::tile_req_t   req_i,
  input  wire                   adv_i,
  output logic                  valid_o,
  output logic                  emit_o,
  output mlbs_pkg::tile_res_t   res_o
);

  logic [mlbs_pkg::SUM_W-1:0] mem [mlbs_pkg::PART_DEPTH];
  logic [mlbs_pkg::SUM_W-1:0] rdata_q;
  logic [mlbs_pkg::SUM_W-1:0] last_part_q;
  logic [mlbs_pkg::SUM_W-1:0] base;
  logic [mlbs_pkg::SUM_W-1:0] part;
  mlbs_pkg::tile_req_t        s1_q;
  logic                       valid_q;
  logic                       fwd_q;
  logic                       wr_en;

  assign wr_en = valid_q && adv_i;
  assign base  = fwd_q ? last_part_q : rdata_q;
  assign part  = s1_q.first ? s1_q.acc : base + s1_q.acc;

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      rdata_q <= mem[req_i.tc];
    end
    if (wr_en) begin
      mem[s1_q.tc] <= part;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_q <= req_i;
    end
    if (wr_en) begin
      last_part_q <= part;
    end
  end

  // same column written back while being read again
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      if (issue_i) begin
        valid_q <= 1'b1;
        fwd_q   <= wr_en && (s1_q.tc == req_i.tc);
      end else if (adv_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign valid_o  = valid_q;
  assign emit_o   = valid_q && s1_q.emit;
  assign res_o.sum  = part;
  assign res_o.row  = s1_q.row;
  assign res_o.col  = s1_q.tc;
  assign res_o.last = s1_q.last;

endmodule
`default_nettype wire
